[design/sts_pkg.sv]
package sts_pkg;

    localparam int CODE_W    = 3;
    localparam int TIME_W    = 32;
    localparam int RIDX_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int NUM_CODES = 6;
    localparam int CFG_IDX_W = 4;

    // opcodes of the input transaction
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEERING    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL       = 4'd3;

    // error log entry codes, also the order of the self-test checks
    localparam logic [CODE_W-1:0] CODE_EMPTY    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_PEDAL    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_STEERING = 3'd2;
    localparam logic [CODE_W-1:0] CODE_CURRENT  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_TEMP     = 3'd4;
    localparam logic [CODE_W-1:0] CODE_WHEELS   = 3'd5;
    localparam logic [CODE_W-1:0] CODE_RELAYS   = 3'd6;

    typedef enum logic [2:0] {
        MS_OFF      = 3'd0,
        MS_PRECHECK = 3'd1,
        MS_READY    = 3'd2,
        MS_RUN      = 3'd3,
        MS_ERROR    = 3'd4
    } mstate_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CHECK,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic              pedal_ready;
        logic              steering_ready;
        logic              current_ready;
        logic              temperature_ready;
        logic              wheels_ready;
        logic              relays_ready;
        logic [TIME_W-1:0] now_ms;
        logic [RIDX_W-1:0] read_index;
    } in_t;

    typedef struct packed {
        logic [2:0]         machine_state;
        logic               power_disable;
        logic               health_ok;
        logic               steering_healthy;
        logic               current_healthy;
        logic               temperature_healthy;
        logic               wheels_healthy;
        logic [COUNT_W-1:0] log_count;
        logic [CODE_W-1:0]  entry_code;
        logic [TIME_W-1:0]  entry_time;
    } out_t;

    // command from the sequencer to the error log
    typedef struct packed {
        logic              ins;
        logic              clr;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] stamp;
    } log_cmd_t;

endpackage

[design/self_test_supervisor_error_log.sv]
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_data   (in_t)
// m_        out        m_valid / m_ready    m_data   (out_t)
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// an update in precheck goes through accept, six check steps (at most one
// log insert per cycle through the shared log unit), then the result load
// other transactions go through accept, then the result load
// synchronous active-low reset: state off, log empty, all checks enabled
// s_ready is high only while the sequencer is idle; a result waiting on
// m_ready holds the sequencer in its finish step, not the input side
module self_test_supervisor_error_log
    import sts_pkg::*;
#(
    parameter int LOG_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    // sequencer and item registers
    seq_state_t        seq_reg,   seq_next;
    in_t               item_reg,  item_next;
    logic [CODE_W-1:0] chk_reg,   chk_next;
    mstate_t           mstate_reg, mstate_next;

    // self-test outcome flags of the current transaction
    logic ok_reg, ok_next;
    logic s_ok_reg, s_ok_next;
    logic c_ok_reg, c_ok_next;
    logic t_ok_reg, t_ok_next;
    logic w_ok_reg, w_ok_next;

    // check enables
    logic steer_en_reg, steer_en_next;
    logic cur_en_reg,   cur_en_next;
    logic temp_en_reg,  temp_en_next;
    logic wheel_en_reg, wheel_en_next;

    // output register
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg,  m_data_next;

    // log interface
    log_cmd_t           log_cmd;
    logic [COUNT_W-1:0] log_fill;
    logic [CODE_W-1:0]  log_code;
    logic [TIME_W-1:0]  log_time;
    logic               fail;
    logic               pdis;

    sts_log #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_log (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (log_cmd),
        .rd_index (item_reg.read_index),
        .fill     (log_fill),
        .rd_code  (log_code),
        .rd_time  (log_time)
    );

    assign s_ready   = (seq_reg == SEQ_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // configuration writes, unknown indexes ignored
    always_comb begin
        steer_en_next = steer_en_reg;
        cur_en_next   = cur_en_reg;
        temp_en_next  = temp_en_reg;
        wheel_en_next = wheel_en_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STEERING:    steer_en_next = cfg_data;
                CFG_CURRENT:     cur_en_next   = cfg_data;
                CFG_TEMPERATURE: temp_en_next  = cfg_data;
                CFG_WHEEL:       wheel_en_next = cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: one check per cycle, each failure is one log insert
    always_comb begin
        seq_next     = seq_reg;
        item_next    = item_reg;
        chk_next     = chk_reg;
        mstate_next  = mstate_reg;
        ok_next      = ok_reg;
        s_ok_next    = s_ok_reg;
        c_ok_next    = c_ok_reg;
        t_ok_next    = t_ok_reg;
        w_ok_next    = w_ok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        log_cmd      = '0;
        fail         = 1'b0;
        pdis         = 1'b0;

        unique case (seq_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    chk_next  = CODE_PEDAL;
                    ok_next   = 1'b1;
                    s_ok_next = 1'b1;
                    c_ok_next = 1'b1;
                    t_ok_next = 1'b1;
                    w_ok_next = 1'b1;
                    if (s_data.opcode == OP_UPDATE && mstate_reg == MS_PRECHECK) begin
                        seq_next = SEQ_CHECK;
                    end else begin
                        seq_next = SEQ_FINISH;
                    end
                end
            end

            SEQ_CHECK: begin
                unique case (chk_reg)
                    CODE_PEDAL: fail = !item_reg.pedal_ready;
                    CODE_STEERING: begin
                        fail = steer_en_reg && !item_reg.steering_ready;
                        if (fail) s_ok_next = 1'b0;
                    end
                    CODE_CURRENT: begin
                        fail = cur_en_reg && !item_reg.current_ready;
                        if (fail) c_ok_next = 1'b0;
                    end
                    CODE_TEMP: begin
                        fail = temp_en_reg && !item_reg.temperature_ready;
                        if (fail) t_ok_next = 1'b0;
                    end
                    CODE_WHEELS: begin
                        fail = wheel_en_reg && !item_reg.wheels_ready;
                        if (fail) w_ok_next = 1'b0;
                    end
                    CODE_RELAYS: fail = !item_reg.relays_ready;
                    default: fail = 1'b0;
                endcase
                if (fail) begin
                    ok_next       = 1'b0;
                    log_cmd.ins   = 1'b1;
                    log_cmd.code  = chk_reg;
                    log_cmd.stamp = item_reg.now_ms;
                end
                if (chk_reg == CODE_RELAYS) begin
                    seq_next = SEQ_FINISH;
                end else begin
                    chk_next = chk_reg + 3'd1;
                end
            end

            SEQ_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    unique case (item_reg.opcode)
                        OP_INIT: mstate_next = MS_PRECHECK;
                        OP_UPDATE: begin
                            unique case (mstate_reg)
                                MS_PRECHECK: mstate_next = ok_reg ? MS_READY : MS_ERROR;
                                MS_READY:    mstate_next = MS_RUN;
                                MS_ERROR:    pdis        = 1'b1;
                                default: ;
                            endcase
                        end
                        OP_CLEAR: log_cmd.clr = 1'b1;
                        default: ;
                    endcase
                    m_data_next.machine_state       = mstate_next;
                    m_data_next.power_disable       = pdis;
                    m_data_next.health_ok           = ok_reg;
                    m_data_next.steering_healthy    = s_ok_reg;
                    m_data_next.current_healthy     = c_ok_reg;
                    m_data_next.temperature_healthy = t_ok_reg;
                    m_data_next.wheels_healthy      = w_ok_reg;
                    // a clear empties the log in this same cycle
                    if (item_reg.opcode == OP_CLEAR) begin
                        m_data_next.log_count  = '0;
                        m_data_next.entry_code = CODE_EMPTY;
                        m_data_next.entry_time = '0;
                    end else begin
                        m_data_next.log_count  = log_fill;
                        m_data_next.entry_code = log_code;
                        m_data_next.entry_time = log_time;
                    end
                    m_valid_next = 1'b1;
                    seq_next     = SEQ_IDLE;
                end
            end

            default: seq_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        chk_reg    <= chk_next;
        ok_reg     <= ok_next;
        s_ok_reg   <= s_ok_next;
        c_ok_reg   <= c_ok_next;
        t_ok_reg   <= t_ok_next;
        w_ok_reg   <= w_ok_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            seq_reg      <= SEQ_IDLE;
            mstate_reg   <= MS_OFF;
            m_valid_reg  <= 1'b0;
            steer_en_reg <= 1'b1;
            cur_en_reg   <= 1'b1;
            temp_en_reg  <= 1'b1;
            wheel_en_reg <= 1'b1;
        end else begin
            seq_reg      <= seq_next;
            mstate_reg   <= mstate_next;
            m_valid_reg  <= m_valid_next;
            steer_en_reg <= steer_en_next;
            cur_en_reg   <= cur_en_next;
            temp_en_reg  <= temp_en_next;
            wheel_en_reg <= wheel_en_next;
        end
    end

endmodule

[design/sts_log.sv]
module sts_log
    import sts_pkg::*;
#(
    parameter int LOG_DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  log_cmd_t           cmd,
    input  logic [RIDX_W-1:0]  rd_index,
    output logic [COUNT_W-1:0] fill,
    output logic [CODE_W-1:0]  rd_code,
    output logic [TIME_W-1:0]  rd_time
);

    // entries are distinct codes, so no more than NUM_CODES slots are ever used
    localparam int SLOTS = (LOG_DEPTH < NUM_CODES) ? LOG_DEPTH : NUM_CODES;

    logic [CODE_W-1:0]    code_reg [SLOTS];
    logic [CODE_W-1:0]    code_next[SLOTS];
    logic [TIME_W-1:0]    time_reg [SLOTS];
    logic [TIME_W-1:0]    time_next[SLOTS];
    logic [COUNT_W-1:0]   fill_reg,    fill_next;
    logic [NUM_CODES-1:0] present_reg, present_next;
    logic [CODE_W-1:0]    new_bit;
    logic [CODE_W-1:0]    old_bit;

    assign new_bit = cmd.code - 3'd1;
    assign old_bit = code_reg[0] - 3'd1;

    always_comb begin
        code_next    = code_reg;
        time_next    = time_reg;
        fill_next    = fill_reg;
        present_next = present_reg;
        if (cmd.clr) begin
            fill_next    = '0;
            present_next = '0;
        end else if (cmd.ins && !present_reg[new_bit]) begin
            if (fill_reg < COUNT_W'(SLOTS)) begin
                // append at the fill position
                for (int k = 0; k < SLOTS; k++) begin
                    if (fill_reg == COUNT_W'(k)) begin
                        code_next[k] = cmd.code;
                        time_next[k] = cmd.stamp;
                    end
                end
                fill_next = fill_reg + 4'd1;
            end else begin
                // full: drop the oldest, move the rest down
                for (int k = 1; k < SLOTS; k++) begin
                    code_next[k-1] = code_reg[k];
                    time_next[k-1] = time_reg[k];
                end
                code_next[SLOTS-1]    = cmd.code;
                time_next[SLOTS-1]    = cmd.stamp;
                present_next[old_bit] = 1'b0;
            end
            present_next[new_bit] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        time_reg <= time_next;
        if (!aresetn) begin
            fill_reg    <= '0;
            present_reg <= '0;
        end else begin
            fill_reg    <= fill_next;
            present_reg <= present_next;
        end
    end

    // slots at or beyond the fill count read as empty
    always_comb begin
        rd_code = CODE_EMPTY;
        rd_time = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (rd_index == RIDX_W'(k) && COUNT_W'(k) < fill_reg) begin
                rd_code = code_reg[k];
                rd_time = time_reg[k];
            end
        end
    end

    assign fill = fill_reg;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import sts_pkg::*;

    localparam int LOG_DEPTH = 8;
    localparam int SETTLE_CYCLES = 16;
    // opcode 3 has no meaning, the block must hold everything
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // ready flags packed as {pedal, steering, current, temperature, wheels, relays}
    localparam logic [5:0] ALL_READY = 6'h3f;
    localparam logic [5:0] NONE_READY = 6'h00;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER [4] =
        '{CFG_STEERING, CFG_CURRENT, CFG_TEMPERATURE, CFG_WHEEL};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;

    // idle and stall rates in percent, changed per phase
    int send_idle_pct;
    int recv_stall_pct;
    int error_count = 0;

    // shadow copy of the supervisor state
    mstate_t           sup_state;
    logic [CODE_W-1:0] sup_codes [LOG_DEPTH];
    logic [TIME_W-1:0] sup_times [LOG_DEPTH];
    int unsigned       sup_fill;
    logic [3:0]        sup_enable;

    // one expected status per accepted transaction, oldest first
    out_t pending_status [$];
    out_t oldest_status;

    self_test_supervisor_error_log #(
        .LOG_DEPTH(LOG_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // shadow model of the supervisor
    // ---------------------------------------------------------------------

    // deduplicated insert, oldest entry drops out of a full log
    function automatic void log_failure(logic [CODE_W-1:0] code, logic [TIME_W-1:0] stamp);
        bit seen;
        seen = 1'b0;
        for (int i = 0; i < LOG_DEPTH; i++) begin
            if (i < sup_fill && sup_codes[i] == code) seen = 1'b1;
        end
        if (!seen) begin
            if (sup_fill < LOG_DEPTH) begin
                sup_codes[sup_fill] = code;
                sup_times[sup_fill] = stamp;
                sup_fill++;
            end else begin
                for (int i = 1; i < LOG_DEPTH; i++) begin
                    sup_codes[i-1] = sup_codes[i];
                    sup_times[i-1] = sup_times[i];
                end
                sup_codes[LOG_DEPTH-1] = code;
                sup_times[LOG_DEPTH-1] = stamp;
            end
        end
    endfunction

    function automatic void clear_shadow();
        sup_state = MS_OFF;
        sup_fill = 0;
        for (int i = 0; i < LOG_DEPTH; i++) begin
            sup_codes[i] = CODE_EMPTY;
            sup_times[i] = '0;
        end
    endfunction

    // advance the shadow state by one transaction and return the status it reports
    function automatic out_t supervise(in_t t);
        out_t st;
        st = '0;
        st.health_ok = 1'b1;
        st.steering_healthy = 1'b1;
        st.current_healthy = 1'b1;
        st.temperature_healthy = 1'b1;
        st.wheels_healthy = 1'b1;
        case (t.opcode)
            OP_INIT: begin
                sup_state = MS_PRECHECK;
            end
            OP_UPDATE: begin
                case (sup_state)
                    MS_PRECHECK: begin
                        // check order sets the order of the log entries
                        if (!t.pedal_ready) begin
                            log_failure(CODE_PEDAL, t.now_ms);
                            st.health_ok = 1'b0;
                        end
                        if (sup_enable[CFG_STEERING] && !t.steering_ready) begin
                            log_failure(CODE_STEERING, t.now_ms);
                            st.steering_healthy = 1'b0;
                            st.health_ok = 1'b0;
                        end
                        if (sup_enable[CFG_CURRENT] && !t.current_ready) begin
                            log_failure(CODE_CURRENT, t.now_ms);
                            st.current_healthy = 1'b0;
                            st.health_ok = 1'b0;
                        end
                        if (sup_enable[CFG_TEMPERATURE] && !t.temperature_ready) begin
                            log_failure(CODE_TEMP, t.now_ms);
                            st.temperature_healthy = 1'b0;
                            st.health_ok = 1'b0;
                        end
                        if (sup_enable[CFG_WHEEL] && !t.wheels_ready) begin
                            log_failure(CODE_WHEELS, t.now_ms);
                            st.wheels_healthy = 1'b0;
                            st.health_ok = 1'b0;
                        end
                        if (!t.relays_ready) begin
                            log_failure(CODE_RELAYS, t.now_ms);
                            st.health_ok = 1'b0;
                        end
                        sup_state = st.health_ok ? MS_READY : MS_ERROR;
                    end
                    MS_READY: begin
                        sup_state = MS_RUN;
                    end
                    MS_ERROR: begin
                        st.power_disable = 1'b1;
                    end
                    default: begin
                        // off and run hold
                    end
                endcase
            end
            OP_CLEAR: begin
                sup_fill = 0;
                for (int i = 0; i < LOG_DEPTH; i++) begin
                    sup_codes[i] = CODE_EMPTY;
                    sup_times[i] = '0;
                end
            end
            default: begin
                // unused opcode changes nothing
            end
        endcase
        st.machine_state = sup_state;
        st.log_count = COUNT_W'(sup_fill);
        if (t.read_index < LOG_DEPTH) begin
            st.entry_code = sup_codes[t.read_index];
            st.entry_time = sup_times[t.read_index];
        end
        return st;
    endfunction

    // ---------------------------------------------------------------------
    // status checker
    // ---------------------------------------------------------------------

    task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t ns: status transaction with none expected, actual %h",
                         $time, m_data);
                error_count++;
            end else begin
                oldest_status = pending_status.pop_front();
                check_field("machine_state", TIME_W'(oldest_status.machine_state),
                            TIME_W'(m_data.machine_state));
                check_field("power_disable", TIME_W'(oldest_status.power_disable),
                            TIME_W'(m_data.power_disable));
                check_field("health_ok", TIME_W'(oldest_status.health_ok),
                            TIME_W'(m_data.health_ok));
                check_field("steering_healthy", TIME_W'(oldest_status.steering_healthy),
                            TIME_W'(m_data.steering_healthy));
                check_field("current_healthy", TIME_W'(oldest_status.current_healthy),
                            TIME_W'(m_data.current_healthy));
                check_field("temperature_healthy",
                            TIME_W'(oldest_status.temperature_healthy),
                            TIME_W'(m_data.temperature_healthy));
                check_field("wheels_healthy", TIME_W'(oldest_status.wheels_healthy),
                            TIME_W'(m_data.wheels_healthy));
                check_field("log_count", TIME_W'(oldest_status.log_count),
                            TIME_W'(m_data.log_count));
                check_field("entry_code", TIME_W'(oldest_status.entry_code),
                            TIME_W'(m_data.entry_code));
                check_field("entry_time", oldest_status.entry_time, m_data.entry_time);
            end
        end
    end

    // ---------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------

    function automatic in_t make_item(logic [1:0] op, logic [5:0] ready,
                                      logic [TIME_W-1:0] stamp, logic [RIDX_W-1:0] idx);
        in_t t;
        t.opcode = op;
        {t.pedal_ready, t.steering_ready, t.current_ready,
         t.temperature_ready, t.wheels_ready, t.relays_ready} = ready;
        t.now_ms = stamp;
        t.read_index = idx;
        return t;
    endfunction

    // mostly healthy subsystems so that both ready and error paths are common
    function automatic logic [5:0] draw_flags();
        logic [5:0] f;
        if ($urandom_range(9, 0) == 0) begin
            f = 6'($urandom);
        end else begin
            for (int i = 0; i < 6; i++) f[i] = ($urandom_range(99, 0) < 82);
        end
        return f;
    endfunction

    // valid stays up across back-to-back transactions, dropped only for a gap
    task automatic send_item(in_t t);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_status.push_back(supervise(t));
    endtask

    // hold the input side until every status has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // writes all four enables in a row, only from an idle block
    task automatic write_enables(logic [3:0] en);
        drain_results();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_ORDER[i];
            cfg_data <= en[CFG_ORDER[i]];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sup_enable[CFG_ORDER[i]] = en[CFG_ORDER[i]];
        end
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // out of reset the machine is off and updates, an unused opcode and a clear change nothing
    task automatic test_off_state();
        send_item(make_item(OP_UPDATE, NONE_READY, 32'h0000_0064, 3'd0));
        send_item(make_item(OP_UNUSED, ALL_READY, 32'hffff_ffff, 3'd7));
        send_item(make_item(OP_CLEAR, NONE_READY, 32'h0, 3'd3));
    endtask

    // clean self-test: precheck, ready, run, and run holds
    task automatic test_clean_start();
        send_item(make_item(OP_INIT, ALL_READY, 32'h0, 3'd0));
        send_item(make_item(OP_UPDATE, ALL_READY, 32'h0000_00c8, 3'd0));
        send_item(make_item(OP_UPDATE, NONE_READY, 32'h0000_012c, 3'd1));
        send_item(make_item(OP_UPDATE, NONE_READY, 32'h0000_0190, 3'd2));
    endtask

    // every check fails, then power disable, duplicates, clear and unused opcode
    task automatic test_failure_logging();
        send_item(make_item(OP_INIT, ALL_READY, 32'h0, 3'd0));
        send_item(make_item(OP_UPDATE, NONE_READY, 32'hffff_ffff, 3'd5));
        send_item(make_item(OP_UPDATE, ALL_READY, 32'h0000_01f4, 3'd0));
        // init from error keeps the log
        send_item(make_item(OP_INIT, ALL_READY, 32'h0000_0258, 3'd2));
        // duplicates keep their first time stamp
        send_item(make_item(OP_UPDATE, 6'b011110, 32'h0000_0000, 3'd0));
        send_item(make_item(OP_UNUSED, NONE_READY, 32'haaaa_5555, 3'd6));
        send_item(make_item(OP_CLEAR, ALL_READY, 32'h5555_aaaa, 3'd1));
        send_item(make_item(OP_INIT, ALL_READY, 32'h0, 3'd0));
        send_item(make_item(OP_UPDATE, 6'b101101, 32'h8000_0001, 3'd1));
        send_item(make_item(OP_UPDATE, ALL_READY, 32'h0, 3'd7));
    endtask

    // with the optional checks off only pedal and relays can fail
    task automatic test_disabled_checks();
        write_enables(4'b0000);
        send_item(make_item(OP_CLEAR, ALL_READY, 32'h0, 3'd0));
        send_item(make_item(OP_INIT, ALL_READY, 32'h0, 3'd0));
        send_item(make_item(OP_UPDATE, 6'b100001, 32'h1234_5678, 3'd0));
        send_item(make_item(OP_INIT, ALL_READY, 32'h0, 3'd0));
        send_item(make_item(OP_UPDATE, NONE_READY, 32'hfedc_ba98, 3'd1));
        write_enables(4'b1111);
    endtask

    // well-formed init and update runs with random content, plus some noise
    task automatic test_random_traffic(int n_items);
        int sent;
        int pick;
        int extra;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 78) begin
                send_item(make_item(OP_INIT, draw_flags(), $urandom, 3'($urandom)));
                send_item(make_item(OP_UPDATE, draw_flags(), $urandom, 3'($urandom)));
                extra = $urandom_range(3, 0);
                repeat (extra) begin
                    send_item(make_item(OP_UPDATE, draw_flags(), $urandom, 3'($urandom)));
                end
                sent += 2 + extra;
            end else if (pick < 88) begin
                send_item(make_item(OP_CLEAR, draw_flags(), $urandom, 3'($urandom)));
                sent++;
            end else begin
                send_item(make_item(2'($urandom), 6'($urandom), $urandom, 3'($urandom)));
                sent++;
            end
            // occasional full stop on the input side
            if ($urandom_range(59, 0) == 0) drain_results();
        end
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = 1'b0;
        sup_enable = 4'b1111;
        clear_shadow();

        // first phase: sender idles lightly, receiver stalls heavily
        send_idle_pct = 28;
        recv_stall_pct = 74;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_off_state();
        test_clean_start();
        test_failure_logging();
        test_disabled_checks();

        write_enables(4'($urandom));
        test_random_traffic(540);

        // second phase: rates swapped
        write_enables(4'($urandom));
        send_idle_pct = 74;
        recv_stall_pct = 28;
        test_random_traffic(540);

        // last phase: full throughput, all checks enabled
        write_enables(4'b1111);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(540);

        drain_results();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
